FILE: src/tsr_pkg.sv
// Shared constants and types of the TCP stream reassembler.
// No dependencies; used by tsr_ctl and tcp_stream_reassembler_top.
`default_nettype none

package tsr_pkg;

    localparam int DEF_CAPACITY = 64;

    localparam int OP_W   = 2;
    localparam int IDX_W  = 64;
    localparam int BYTE_W = 8;
    localparam int REL_W  = 7;
    localparam int PEND_W = 7;

    // A store slot holds the present flag above the payload byte.
    localparam int SLOT_W = BYTE_W + 1;

    localparam logic [OP_W-1:0] OP_SEG     = 2'd0;
    localparam logic [OP_W-1:0] OP_EMPTY   = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

    typedef struct packed {
        logic              out_valid;
        logic [BYTE_W-1:0] out_byte;
        logic              stream_closed;
        logic [PEND_W-1:0] pending_bytes;
        logic              run_last;
    } t_result;

endpackage

`default_nettype wire

FILE: src/tsr_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module tsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: src/tsr_ctl.sv
// Sequencer of the reassembler: window check, store, in-order drain and close.
// Depends on tsr_pkg; drives one tsr_ram holding the present flag and byte of each slot.
`default_nettype none

module tsr_ctl #(
    parameter int CAPACITY = tsr_pkg::DEF_CAPACITY
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // input words
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [tsr_pkg::OP_W-1:0]    i_op,
    input  wire logic [tsr_pkg::IDX_W-1:0]   i_stream_index,
    input  wire logic [tsr_pkg::BYTE_W-1:0]  i_data_byte,
    input  wire logic                        i_segment_end,
    input  wire logic                        i_final_segment,
    input  wire logic [tsr_pkg::REL_W-1:0]   i_release_count,
    // result push towards the output register
    output logic                             o_push,
    output tsr_pkg::t_result                 o_res,
    input  wire logic                        i_res_free,
    // store memory
    output logic                             o_mem_we,
    output logic [$clog2(CAPACITY)-1:0]      o_mem_waddr,
    output logic [tsr_pkg::SLOT_W-1:0]       o_mem_wdata,
    output logic                             o_mem_re,
    output logic [$clog2(CAPACITY)-1:0]      o_mem_raddr,
    input  wire logic [tsr_pkg::SLOT_W-1:0]  i_mem_rdata
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int UW    = $clog2(CAPACITY + 1);
    localparam int IDX_W = tsr_pkg::IDX_W;
    localparam int BW    = tsr_pkg::BYTE_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_RD,
        S_STORE,
        S_DRD,
        S_DCHK
    } t_state;

    t_state                    r_state, n_state;
    logic [AW-1:0]             r_clr_cnt, n_clr_cnt;
    logic [tsr_pkg::OP_W-1:0]  r_op, n_op;
    logic [IDX_W-1:0]          r_idx, n_idx;
    logic [BW-1:0]             r_byte, n_byte;
    logic                      r_segend, n_segend;
    logic                      r_fin, n_fin;
    logic [tsr_pkg::REL_W-1:0] r_rel, n_rel;
    logic [IDX_W-1:0]          r_emitted, n_emitted;
    logic [IDX_W-1:0]          r_released, n_released;
    logic [IDX_W-1:0]          r_final_pos, n_final_pos;
    logic                      r_final_known, n_final_known;
    logic                      r_closed, n_closed;
    logic [UW-1:0]             r_stored, n_stored;
    logic [AW-1:0]             r_eslot, n_eslot;
    logic                      r_keep, n_keep;
    logic [AW-1:0]             r_diff, n_diff;
    logic [AW-1:0]             r_slot, n_slot;
    logic                      r_hold_valid, n_hold_valid;
    logic [BW-1:0]             r_hold_byte, n_hold_byte;

    logic [UW-1:0]    unread;
    logic [UW-1:0]    avail;
    logic             fin_mark;
    logic [IDX_W-1:0] fp_inc;
    logic [IDX_W-1:0] diff;
    logic             past_final;
    logic             in_window;
    logic [IDX_W-1:0] rel_ext;
    logic [IDX_W-1:0] unread_ext;
    logic [AW:0]      slot_sum;
    logic [AW-1:0]    slot;
    logic [AW-1:0]    eslot_inc;
    logic             reached;
    logic             slot_present;

    // Unread bytes never exceed the capacity, so the low bits of the counters suffice.
    assign unread     = r_emitted[UW-1:0] - r_released[UW-1:0];
    assign avail      = UW'(CAPACITY) - unread;
    assign fin_mark   = r_fin && r_segend;
    assign fp_inc     = (&r_idx) ? r_idx : r_idx + IDX_W'(1);
    assign diff       = r_idx - r_emitted;
    // A new final marker from this byte excludes the byte itself only when it saturated.
    assign past_final = fin_mark ? (&r_idx) : (r_final_known && (r_idx >= r_final_pos));
    assign in_window  = (r_idx >= r_emitted) && (diff[IDX_W-1:AW] == '0)
                        && (UW'(diff[AW-1:0]) < avail) && !past_final;
    assign rel_ext    = IDX_W'(r_rel);
    assign unread_ext = IDX_W'(unread);
    assign slot_sum   = (AW+1)'(r_eslot) + (AW+1)'(r_diff);
    assign slot       = (slot_sum >= (AW+1)'(CAPACITY)) ?
                        AW'(slot_sum - (AW+1)'(CAPACITY)) : AW'(slot_sum);
    assign eslot_inc  = (r_eslot == AW'(CAPACITY - 1)) ? '0 : r_eslot + AW'(1);
    assign reached    = r_final_known && (r_emitted >= r_final_pos);
    assign slot_present = i_mem_rdata[tsr_pkg::SLOT_W-1];

    always_comb begin
        n_state       = r_state;
        n_clr_cnt     = r_clr_cnt;
        n_op          = r_op;
        n_idx         = r_idx;
        n_byte        = r_byte;
        n_segend      = r_segend;
        n_fin         = r_fin;
        n_rel         = r_rel;
        n_emitted     = r_emitted;
        n_released    = r_released;
        n_final_pos   = r_final_pos;
        n_final_known = r_final_known;
        n_closed      = r_closed;
        n_stored      = r_stored;
        n_eslot       = r_eslot;
        n_keep        = r_keep;
        n_diff        = r_diff;
        n_slot        = r_slot;
        n_hold_valid  = r_hold_valid;
        n_hold_byte   = r_hold_byte;

        o_ready     = 1'b0;
        o_push      = 1'b0;
        o_res       = '0;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_eslot;
        o_mem_wdata = '0;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_eslot;

        case (r_state)
            S_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_clr_cnt;
                n_clr_cnt   = r_clr_cnt + AW'(1);
                if (r_clr_cnt == AW'(CAPACITY - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_op     = i_op;
                    n_idx    = i_stream_index;
                    n_byte   = i_data_byte;
                    n_segend = i_segment_end;
                    n_fin    = i_final_segment;
                    n_rel    = i_release_count;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!r_closed && r_op == tsr_pkg::OP_SEG) begin
                    if (fin_mark) begin
                        n_final_known = 1'b1;
                        n_final_pos   = fp_inc;
                    end
                    n_keep  = in_window;
                    n_diff  = diff[AW-1:0];
                    n_state = S_RD;
                end else if (!r_closed && r_op == tsr_pkg::OP_EMPTY) begin
                    if (r_fin) begin
                        n_final_known = 1'b1;
                        n_final_pos   = r_idx;
                    end
                    n_state = S_DRD;
                end else begin
                    // Releases, unknown codes and words after close give one status word.
                    o_res.stream_closed = r_closed;
                    o_res.pending_bytes = tsr_pkg::PEND_W'(r_stored);
                    o_res.run_last      = 1'b1;
                    if (i_res_free) begin
                        o_push = 1'b1;
                        if (r_op == tsr_pkg::OP_RELEASE) begin
                            n_released = r_released +
                                         ((rel_ext > unread_ext) ? unread_ext : rel_ext);
                        end
                        n_state = S_IDLE;
                    end
                end
            end
            S_RD: begin
                if (r_keep) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = slot;
                    n_slot      = slot;
                    n_state     = S_STORE;
                end else begin
                    n_state = S_DRD;
                end
            end
            S_STORE: begin
                // A duplicate leaves the stored copy and the count untouched.
                if (!slot_present) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_slot;
                    o_mem_wdata = {1'b1, r_byte};
                    n_stored    = r_stored + UW'(1);
                end
                n_state = S_DRD;
            end
            S_DRD: begin
                if (reached) begin
                    o_res.out_valid     = r_hold_valid;
                    o_res.out_byte      = r_hold_valid ? r_hold_byte : '0;
                    o_res.stream_closed = 1'b1;
                    o_res.run_last      = 1'b1;
                    if (i_res_free) begin
                        o_push       = 1'b1;
                        n_closed     = 1'b1;
                        n_stored     = '0;
                        n_hold_valid = 1'b0;
                        n_state      = S_IDLE;
                    end
                end else begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = r_eslot;
                    n_state     = S_DCHK;
                end
            end
            S_DCHK: begin
                o_res.out_valid     = r_hold_valid;
                o_res.out_byte      = r_hold_valid ? r_hold_byte : '0;
                o_res.pending_bytes = tsr_pkg::PEND_W'(r_stored);
                if (slot_present) begin
                    // The held word goes out only once a further byte proves it is not last.
                    if (!r_hold_valid || i_res_free) begin
                        o_push       = r_hold_valid;
                        o_mem_we     = 1'b1;
                        o_mem_waddr  = r_eslot;
                        n_hold_valid = 1'b1;
                        n_hold_byte  = i_mem_rdata[BW-1:0];
                        n_stored     = r_stored - UW'(1);
                        n_emitted    = r_emitted + IDX_W'(1);
                        n_eslot      = eslot_inc;
                        n_state      = S_DRD;
                    end
                end else begin
                    o_res.run_last = 1'b1;
                    if (i_res_free) begin
                        o_push       = 1'b1;
                        n_hold_valid = 1'b0;
                        n_state      = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_cnt     <= '0;
            r_emitted     <= '0;
            r_released    <= '0;
            r_final_pos   <= '0;
            r_final_known <= 1'b0;
            r_closed      <= 1'b0;
            r_stored      <= '0;
            r_eslot       <= '0;
            r_hold_valid  <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_clr_cnt     <= n_clr_cnt;
            r_emitted     <= n_emitted;
            r_released    <= n_released;
            r_final_pos   <= n_final_pos;
            r_final_known <= n_final_known;
            r_closed      <= n_closed;
            r_stored      <= n_stored;
            r_eslot       <= n_eslot;
            r_hold_valid  <= n_hold_valid;
        end
        r_op        <= n_op;
        r_idx       <= n_idx;
        r_byte      <= n_byte;
        r_segend    <= n_segend;
        r_fin       <= n_fin;
        r_rel       <= n_rel;
        r_keep      <= n_keep;
        r_diff      <= n_diff;
        r_slot      <= n_slot;
        r_hold_byte <= n_hold_byte;
    end

endmodule

`default_nettype wire

FILE: src/tcp_stream_reassembler_top.sv
// TCP byte-stream reassembler. Each input word is one stream byte with its absolute index, an
// empty segment or a consumer release; bytes inside the receive window are stored in a slot
// memory and emitted in order, one result word per byte, the last word of each input marked.
// One input word is taken at a time. A release, an unknown code or any word after close is
// answered from the execute state; an empty segment goes on to the drain, a segment byte first
// reads its slot and stores itself if the slot is empty (a dropped byte skips both), then drains.
// The drain runs as a read-check-clear loop on the single store memory with its registered read,
// one pass per byte it drains. A word that closes the stream skips the last check. Stalls on the
// result side can hold the execute, drain and check states. After reset a clearing pass
// sweeps every slot of the store before the first word is taken. An output register
// decouples the result side. Depends on tsr_pkg, tsr_ctl and tsr_ram.
`default_nettype none

module tcp_stream_reassembler_top #(
    parameter int CAPACITY = tsr_pkg::DEF_CAPACITY
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [tsr_pkg::OP_W-1:0]    i_op,
    input  wire logic [tsr_pkg::IDX_W-1:0]   i_stream_index,
    input  wire logic [tsr_pkg::BYTE_W-1:0]  i_data_byte,
    input  wire logic                        i_segment_end,
    input  wire logic                        i_final_segment,
    input  wire logic [tsr_pkg::REL_W-1:0]   i_release_count,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic                             o_out_valid,
    output logic      [tsr_pkg::BYTE_W-1:0]  o_out_byte,
    output logic                             o_stream_closed,
    output logic      [tsr_pkg::PEND_W-1:0]  o_pending_bytes,
    output logic                             o_run_last
);

    localparam int AW = $clog2(CAPACITY);

    logic                       push;
    tsr_pkg::t_result           res;
    logic                       res_free;
    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic [tsr_pkg::SLOT_W-1:0] mem_wdata;
    logic                       mem_re;
    logic [AW-1:0]              mem_raddr;
    logic [tsr_pkg::SLOT_W-1:0] mem_rdata;

    logic             r_valid;
    tsr_pkg::t_result r_res;

    assign res_free = !r_valid || i_ready;

    tsr_ctl #(
        .CAPACITY (CAPACITY)
    ) u_ctl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_op            (i_op),
        .i_stream_index  (i_stream_index),
        .i_data_byte     (i_data_byte),
        .i_segment_end   (i_segment_end),
        .i_final_segment (i_final_segment),
        .i_release_count (i_release_count),
        .o_push          (push),
        .o_res           (res),
        .i_res_free      (res_free),
        .o_mem_we        (mem_we),
        .o_mem_waddr     (mem_waddr),
        .o_mem_wdata     (mem_wdata),
        .o_mem_re        (mem_re),
        .o_mem_raddr     (mem_raddr),
        .i_mem_rdata     (mem_rdata)
    );

    tsr_ram #(
        .WIDTH (tsr_pkg::SLOT_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (push) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (push) begin
            r_res <= res;
        end
    end

    assign o_valid         = r_valid;
    assign o_out_valid     = r_res.out_valid;
    assign o_out_byte      = r_res.out_byte;
    assign o_stream_closed = r_res.stream_closed;
    assign o_pending_bytes = r_res.pending_bytes;
    assign o_run_last      = r_res.run_last;

endmodule

`default_nettype wire
